// ===== rtl/vfgf_pkg.sv =====
// shared types and constants of the voice frame gap filler
`timescale 1ns / 1ps
`default_nettype none

package vfgf_pkg;

    // field widths fixed by the stream format
    localparam int NUM_W = 5;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 2;

    // input opcodes
    localparam logic [1:0] OP_HEADER = 2'd0;
    localparam logic [1:0] OP_DATA   = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // slow data actions
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_SYNC    = 2'd1;
    localparam logic [1:0] ACT_SILENCE = 2'd2;
    localparam logic [1:0] ACT_DATA    = 2'd3;

    // stream events
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_START = 2'd1;
    localparam logic [1:0] EV_END   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HANG_TICKS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCHDOG_TICKS = 2'd3;

    // configuration reset values
    localparam logic [4:0]  GAP_LIMIT_RST      = 5'd18;
    localparam logic [3:0]  SILENCE_TICKS_RST  = 4'd8;
    localparam logic [5:0]  HANG_TICKS_RST     = 6'd30;
    localparam logic [15:0] WATCHDOG_TICKS_RST = 16'd400;

    // largest number of fill frames in front of one data frame
    localparam logic [4:0] MAX_FILL = 5'd18;

    // frame sequence byte bits
    localparam int END_BIT = 6;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  seq_byte;
        logic [63:0] voice_low;
        logic [7:0]  voice_high;
        logic [23:0] slow_bytes;
    } in_item_t;

    typedef struct packed {
        logic        is_silence;
        logic [63:0] voice_out_low;
        logic [7:0]  voice_out_high;
        logic [1:0]  slow_action;
        logic [23:0] slow_out;
        logic [1:0]  stream_event;
        logic        last;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_HDR,
        S_FILL,
        S_FRAME,
        S_TICK_SIL,
        S_TICK_END
    } state_t;

    typedef enum logic [1:0] {
        RES_PLAIN_SIL,
        RES_FILL,
        RES_FRAME,
        RES_END
    } res_kind_t;

    typedef struct packed {
        logic      load_in;
        logic      hdr_init;
        logic      data_update;
        logic      tick_update;
        logic      emit;
        res_kind_t res_kind;
        logic [1:0] ev;
        logic      last;
    } cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       end_bit;
        logic       in_range;
        logic       gap_ok;
        logic       next_eq_n;
        logic       tick_sil;
        logic       tick_end;
        logic       out_free;
    } stat_t;

endpackage

`default_nettype wire

// ===== rtl/vfgf_ctrl.sv =====
// sequencing state machine of the voice frame gap filler
`timescale 1ns / 1ps
`default_nettype none

module vfgf_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire vfgf_pkg::stat_t stat,
    output vfgf_pkg::cmd_t      cmd
);
    import vfgf_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] hdr_cnt_reg, hdr_cnt_next;
    logic       end_reg, end_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            hdr_cnt_reg <= '0;
            end_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            hdr_cnt_reg <= hdr_cnt_next;
            end_reg     <= end_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        hdr_cnt_next = hdr_cnt_reg;
        end_next     = end_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.res_kind = RES_PLAIN_SIL;
        cmd.ev       = EV_NONE;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid)
                    state_next = S_DECODE;
            end

            S_DECODE:
            begin
                state_next = S_IDLE;
                unique case (stat.opcode)
                    OP_HEADER:
                    begin
                        cmd.hdr_init = 1'b1;
                        hdr_cnt_next = '0;
                        state_next   = S_HDR;
                    end
                    OP_DATA:
                    begin
                        cmd.data_update = 1'b1;
                        if (!stat.end_bit && stat.in_range && stat.gap_ok)
                            state_next = stat.next_eq_n ? S_FRAME : S_FILL;
                    end
                    OP_TICK:
                    begin
                        cmd.tick_update = 1'b1;
                        end_next        = stat.tick_end;
                        if (stat.tick_sil)
                            state_next = S_TICK_SIL;
                        else if (stat.tick_end)
                            state_next = S_TICK_END;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            // three silence frames, the first one marks the start
            S_HDR:
            begin
                cmd.res_kind = RES_PLAIN_SIL;
                cmd.ev       = (hdr_cnt_reg == 2'd0) ? EV_START : EV_NONE;
                cmd.last     = (hdr_cnt_reg == 2'd2);
                if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    hdr_cnt_next = hdr_cnt_reg + 2'd1;
                    if (hdr_cnt_reg == 2'd2)
                        state_next = S_IDLE;
                end
            end

            // silence frames up to the received number
            S_FILL:
            begin
                cmd.res_kind = RES_FILL;
                if (stat.next_eq_n)
                    state_next = S_FRAME;
                else if (stat.out_free)
                    cmd.emit = 1'b1;
            end

            S_FRAME:
            begin
                cmd.res_kind = RES_FRAME;
                cmd.last     = 1'b1;
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_TICK_SIL:
            begin
                cmd.res_kind = RES_FILL;
                cmd.ev       = end_reg ? EV_END : EV_NONE;
                cmd.last     = 1'b1;
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_TICK_END:
            begin
                cmd.res_kind = RES_END;
                cmd.ev       = EV_END;
                cmd.last     = 1'b1;
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/vfgf_dp.sv =====
// datapath: configuration, stream state, item and result registers
`timescale 1ns / 1ps
`default_nettype none

module vfgf_dp #(
    parameter int SEQ_MODULUS = 21
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire vfgf_pkg::in_item_t               in_data,
    output vfgf_pkg::out_item_t                   out_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    input  wire logic                             cfg_we,
    input  wire logic [vfgf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [vfgf_pkg::CFG_W-1:0]       cfg_data,
    input  wire vfgf_pkg::cmd_t                   cmd,
    output vfgf_pkg::stat_t                       stat
);
    import vfgf_pkg::*;

    localparam logic [NUM_W:0] MOD = (NUM_W + 1)'(SEQ_MODULUS);

    // configuration registers
    logic [4:0]  gap_limit_reg;
    logic [3:0]  silence_ticks_reg;
    logic [5:0]  hang_ticks_reg;
    logic [15:0] watchdog_ticks_reg;

    // stream state
    logic [NUM_W-1:0] next_number_reg, next_number_next;
    logic             busy_reg, busy_next;
    logic [3:0]       idle_ticks_reg, idle_ticks_next;
    logic [5:0]       hang_left_reg, hang_left_next;
    logic [15:0]      watchdog_count_reg, watchdog_count_next;
    logic             watchdog_running_reg, watchdog_running_next;

    // captured item and result register
    in_item_t  item_reg;
    out_item_t out_reg, out_next;
    logic      out_valid_reg, out_valid_next;

    logic [NUM_W-1:0] num;
    logic [NUM_W:0]   next_inc;
    logic [NUM_W-1:0] next_adv;
    logic [NUM_W:0]   gap;
    logic [4:0]       lim;
    logic [3:0]       idle_inc;
    logic [15:0]      wd_inc;
    logic             wd_end;
    logic             hang_end;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_limit_reg      <= GAP_LIMIT_RST;
            silence_ticks_reg  <= SILENCE_TICKS_RST;
            hang_ticks_reg     <= HANG_TICKS_RST;
            watchdog_ticks_reg <= WATCHDOG_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GAP_LIMIT:      gap_limit_reg      <= cfg_data[4:0];
                CFG_SILENCE_TICKS:  silence_ticks_reg  <= cfg_data[3:0];
                CFG_HANG_TICKS:     hang_ticks_reg     <= cfg_data[5:0];
                CFG_WATCHDOG_TICKS: watchdog_ticks_reg <= cfg_data[15:0];
                default:            gap_limit_reg      <= gap_limit_reg;
            endcase
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            item_reg <= in_data;
    end

    // frame number arithmetic
    always_comb
    begin
        num      = item_reg.seq_byte[NUM_W-1:0];
        next_inc = {1'b0, next_number_reg} + (NUM_W + 1)'(1);
        next_adv = (next_inc >= MOD) ? '0 : next_inc[NUM_W-1:0];
        if (num >= next_number_reg)
            gap = {1'b0, num} - {1'b0, next_number_reg};
        else
            gap = {1'b0, num} + MOD - {1'b0, next_number_reg};
        lim = (gap_limit_reg > MAX_FILL) ? MAX_FILL : gap_limit_reg;
    end

    // tick counters
    always_comb
    begin
        idle_inc = idle_ticks_reg + 4'd1;
        wd_inc   = (watchdog_count_reg == 16'hFFFF) ? watchdog_count_reg
                                                    : watchdog_count_reg + 16'd1;
        wd_end   = watchdog_running_reg && (wd_inc >= watchdog_ticks_reg);
        hang_end = (hang_left_reg == 6'd1);
    end

    // status to the controller
    always_comb
    begin
        stat.opcode    = item_reg.opcode;
        stat.end_bit   = item_reg.seq_byte[END_BIT];
        stat.in_range  = ({1'b0, num} < MOD);
        stat.gap_ok    = (gap <= {1'b0, lim});
        stat.next_eq_n = (next_number_reg == num);
        stat.tick_sil  = busy_reg && (idle_inc == silence_ticks_reg);
        stat.tick_end  = wd_end || hang_end;
        stat.out_free  = !out_valid_reg || out_ready;
    end

    // stream state update
    always_comb
    begin
        next_number_next      = next_number_reg;
        busy_next             = busy_reg;
        idle_ticks_next       = idle_ticks_reg;
        hang_left_next        = hang_left_reg;
        watchdog_count_next   = watchdog_count_reg;
        watchdog_running_next = watchdog_running_reg;

        if (cmd.hdr_init)
        begin
            next_number_next      = '0;
            idle_ticks_next       = '0;
            hang_left_next        = '0;
            watchdog_count_next   = '0;
            watchdog_running_next = 1'b1;
            busy_next             = 1'b1;
        end

        if (cmd.data_update)
        begin
            watchdog_count_next = '0;
            idle_ticks_next     = '0;
            hang_left_next      = item_reg.seq_byte[END_BIT] ? hang_ticks_reg : 6'd0;
        end

        if (cmd.tick_update)
        begin
            if (busy_reg)
                idle_ticks_next = stat.tick_sil ? 4'd0 : idle_inc;
            if (watchdog_running_reg)
                watchdog_count_next = wd_inc;
            if (hang_left_reg != 6'd0)
                hang_left_next = hang_left_reg - 6'd1;
            if (stat.tick_end)
            begin
                busy_next             = 1'b0;
                watchdog_running_next = 1'b0;
            end
        end

        if (cmd.emit && (cmd.res_kind == RES_FILL || cmd.res_kind == RES_FRAME))
            next_number_next = next_adv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_number_reg      <= '0;
            busy_reg             <= 1'b0;
            idle_ticks_reg       <= '0;
            hang_left_reg        <= '0;
            watchdog_count_reg   <= '0;
            watchdog_running_reg <= 1'b0;
        end
        else
        begin
            next_number_reg      <= next_number_next;
            busy_reg             <= busy_next;
            idle_ticks_reg       <= idle_ticks_next;
            hang_left_reg        <= hang_left_next;
            watchdog_count_reg   <= watchdog_count_next;
            watchdog_running_reg <= watchdog_running_next;
        end
    end

    // result formatting
    always_comb
    begin
        out_next              = '0;
        out_next.stream_event = cmd.ev;
        out_next.last         = cmd.last;
        case (cmd.res_kind)
            RES_PLAIN_SIL:
            begin
                out_next.is_silence  = 1'b1;
                out_next.slow_action = ACT_NONE;
            end
            RES_FILL:
            begin
                out_next.is_silence  = 1'b1;
                out_next.slow_action = (next_number_reg == '0) ? ACT_SYNC : ACT_SILENCE;
            end
            RES_FRAME:
            begin
                out_next.voice_out_low  = item_reg.voice_low;
                out_next.voice_out_high = item_reg.voice_high;
                if (num == '0)
                    out_next.slow_action = ACT_SYNC;
                else
                begin
                    out_next.slow_action = ACT_DATA;
                    out_next.slow_out    = item_reg.slow_bytes;
                end
            end
            default:
            begin
                out_next.slow_action = ACT_NONE;
            end
        endcase
    end

    // result register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            out_reg <= out_next;
    end

    assign out_data  = out_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/voice_frame_gap_filler.sv =====
// top level of the voice frame gap filler
//
//   channel   direction  handshake                 payload
//   input     in         in_valid / in_ready       in_data (in_item_t)
//   output    out        out_valid / out_ready     out_data (out_item_t)
//   config    in         cfg_we                    cfg_index, cfg_data
//
// an item passes a capture state and a decode state, then its results
// follow one per cycle while the output register is free; a data frame
// after a gap of g > 0 passes one hand-over step in the fill state between
// the last fill frame and the frame itself; the gap is at most 18 frames
// the controller sequences every result through a single output register
// a stalled output holds the sequencer; the next item is taken once the last
// result of the previous one sits in the output register
// reset clears the stream state and loads the register defaults
`timescale 1ns / 1ps
`default_nettype none

module voice_frame_gap_filler #(
    parameter int SEQ_MODULUS = 21
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire vfgf_pkg::in_item_t               in_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output vfgf_pkg::out_item_t                   out_data,
    input  wire logic                             cfg_we,
    input  wire logic [vfgf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [vfgf_pkg::CFG_W-1:0]       cfg_data
);
    import vfgf_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer
    vfgf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    vfgf_dp #(
        .SEQ_MODULUS (SEQ_MODULUS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire
